// ===== design/num2w_pkg.sv =====
package num2w_pkg;

  // Decimal digits of a 32-bit number, least significant digit at index 0.
  localparam int NumDigits = 10;
  localparam int PosWidth  = $clog2(NumDigits);
  localparam int LastPos   = NumDigits - 1;

  // Width used for the digit-weight compares; 9 * 10^9 needs 34 bits.
  localparam int WeightWidth = 36;

  // Slots of the spoken sequence: four groups of six slots each.
  localparam int NumGroups     = 4;
  localparam int SlotsPerGroup = 6;
  localparam int NumSlots      = NumGroups * SlotsPerGroup;
  localparam int SlotWidth     = $clog2(NumSlots);

  // Slot positions inside one group.
  localparam int SlotHundDigit = 0;
  localparam int SlotHundWord  = 1;
  localparam int SlotAnd       = 2;
  localparam int SlotTens      = 3;
  localparam int SlotOnes      = 4;
  localparam int SlotScale     = 5;

  // Group numbers, most significant first.
  localparam int GroupBillion  = 0;
  localparam int GroupMillion  = 1;
  localparam int GroupThousand = 2;
  localparam int GroupUnits    = 3;

  // Queue between the digit splitter and the token sequencer.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] digits_t;
  typedef logic [5:0] token_t;

  localparam token_t TokZero     = 6'd0;
  localparam token_t TokTeenBase = 6'd10;
  localparam token_t TokTensBase = 6'd18;
  localparam token_t TokHundred  = 6'd28;
  localparam token_t TokThousand = 6'd29;
  localparam token_t TokMillion  = 6'd30;
  localparam token_t TokBillion  = 6'd31;
  localparam token_t TokAnd      = 6'd32;

  // Weight of one decimal position.
  function automatic logic [WeightWidth-1:0] pow10(input logic [PosWidth-1:0] pos);
    logic [WeightWidth-1:0] w;
    case (pos)
      4'd0:    w = 36'd1;
      4'd1:    w = 36'd10;
      4'd2:    w = 36'd100;
      4'd3:    w = 36'd1000;
      4'd4:    w = 36'd10000;
      4'd5:    w = 36'd100000;
      4'd6:    w = 36'd1000000;
      4'd7:    w = 36'd10000000;
      4'd8:    w = 36'd100000000;
      4'd9:    w = 36'd1000000000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/num2w_front.sv =====
module num2w_front
  import num2w_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic [31:0] number_value,
  output logic    push,
  output digits_t push_data,
  input  logic    q_full
);

  logic                   busy;
  logic                   done;
  logic [PosWidth-1:0]    pos;
  logic [31:0]            rem;
  digits_t                digs;
  digit_t                 dig;
  logic [WeightWidth-1:0] sub;
  logic                   accept;

  // One decimal digit per cycle: the largest multiple of the position
  // weight that fits in the remainder.
  always_comb begin
    dig = '0;
    sub = '0;
    for (int d = 1; d <= 9; d++) begin
      if ({4'b0, rem} >= WeightWidth'(d) * pow10(pos)) begin
        dig = 4'(d);
        sub = WeightWidth'(d) * pow10(pos);
      end
    end
  end

  // A finished item leaves as the next one comes in.
  assign push      = busy && done && !q_full;
  assign push_data = digs;
  assign in_stall  = busy && !push;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pos  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      done <= 1'b0;
      pos  <= PosWidth'(LastPos);
    end else if (push) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      if (pos == '0) begin
        done <= 1'b1;
      end else begin
        pos <= pos - 1'b1;
      end
    end
  end

  // Remainder and digit registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= number_value;
    end else if (busy && !done) begin
      rem       <= rem - sub[31:0];
      digs[pos] <= dig;
    end
  end

endmodule

// ===== design/num2w_queue.sv =====
module num2w_queue
  import num2w_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  digits_t push_data,
  output logic    full,
  input  logic    pop,
  output digits_t pop_data,
  output logic    empty
);

  digits_t                entries [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueuePtrW:0]     count;

  assign full     = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/num2w_back.sv =====
module num2w_back
  import num2w_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  digits_t q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output token_t  word_token,
  output logic    last_token
);

  logic [NumSlots-1:0] slot_valid;
  token_t              slot_code [NumSlots];
  logic [NumSlots-1:0] mask;
  token_t              codes [NumSlots];
  logic [NumSlots-1:0] mask_rest;
  logic [SlotWidth-1:0] first;
  digit_t              gh [NumGroups];
  digit_t              gt [NumGroups];
  digit_t              go [NumGroups];
  logic                upper_nz;
  logic                all_zero;
  logic                out_accept;

  // Split the digits into groups of hundreds, tens and ones.
  always_comb begin
    gh[GroupBillion]  = '0;
    gt[GroupBillion]  = '0;
    go[GroupBillion]  = q_data[9];
    gh[GroupMillion]  = q_data[8];
    gt[GroupMillion]  = q_data[7];
    go[GroupMillion]  = q_data[6];
    gh[GroupThousand] = q_data[5];
    gt[GroupThousand] = q_data[4];
    go[GroupThousand] = q_data[3];
    gh[GroupUnits]    = q_data[2];
    gt[GroupUnits]    = q_data[1];
    go[GroupUnits]    = q_data[0];
  end

  assign upper_nz = (q_data[9] != '0) || (q_data[8] != '0) || (q_data[7] != '0) ||
                    (q_data[6] != '0) || (q_data[5] != '0) || (q_data[4] != '0) ||
                    (q_data[3] != '0);
  assign all_zero = !upper_nz && (q_data[2] == '0) && (q_data[1] == '0) &&
                    (q_data[0] == '0);

  // Decide which slots speak and what each one says.
  always_comb begin
    logic   hund_nz;
    logic   rest_nz;
    logic   group_nz;
    logic   joined;
    token_t scale;
    for (int g = 0; g < NumGroups; g++) begin
      hund_nz  = (gh[g] != '0);
      rest_nz  = (gt[g] != '0) || (go[g] != '0);
      group_nz = hund_nz || rest_nz;
      joined   = hund_nz || ((g == GroupUnits) && upper_nz);
      case (g)
        GroupBillion:  scale = TokBillion;
        GroupMillion:  scale = TokMillion;
        GroupThousand: scale = TokThousand;
        default:       scale = TokZero;
      endcase

      slot_valid[g*SlotsPerGroup + SlotHundDigit] = hund_nz;
      slot_code[g*SlotsPerGroup + SlotHundDigit]  = {2'b00, gh[g]};
      slot_valid[g*SlotsPerGroup + SlotHundWord]  = hund_nz;
      slot_code[g*SlotsPerGroup + SlotHundWord]   = TokHundred;
      slot_valid[g*SlotsPerGroup + SlotAnd]       = joined && rest_nz;
      slot_code[g*SlotsPerGroup + SlotAnd]        = TokAnd;

      // Tens word, or a teen word that covers both digits.
      slot_valid[g*SlotsPerGroup + SlotTens] = (gt[g] != '0);
      if (gt[g] == 4'd1) begin
        slot_code[g*SlotsPerGroup + SlotTens] = TokTeenBase + {2'b00, go[g]};
      end else begin
        slot_code[g*SlotsPerGroup + SlotTens] = TokTensBase + {2'b00, gt[g]};
      end

      // Ones word; zero alone speaks as the units ones slot.
      slot_valid[g*SlotsPerGroup + SlotOnes] = ((gt[g] != 4'd1) && (go[g] != '0)) ||
                                               ((g == GroupUnits) && all_zero);
      slot_code[g*SlotsPerGroup + SlotOnes]  = {2'b00, go[g]};

      slot_valid[g*SlotsPerGroup + SlotScale] = group_nz && (g != GroupUnits);
      slot_code[g*SlotsPerGroup + SlotScale]  = scale;
    end
  end

  // Lowest pending slot is the next token.
  always_comb begin
    first = '0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (mask[s]) begin
        first = SlotWidth'(s);
      end
    end
  end

  assign mask_rest  = mask & (mask - 1'b1);
  assign out_valid  = (mask != '0);
  assign word_token = codes[first];
  assign last_token = (mask_rest == '0);
  assign out_accept = out_valid && !out_stall;
  assign pop        = !q_empty && (!out_valid || (out_accept && last_token));

  // Pending slot mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      mask <= slot_valid;
    end else if (out_accept) begin
      mask <= mask_rest;
    end
  end

  // Token codes of the item being spoken.
  always_ff @(posedge clk) begin
    if (pop) begin
      codes <= slot_code;
    end
  end

endmodule

// ===== design/number_to_word_tokens.sv =====
// Speaks an unsigned 32-bit number as British English word tokens.
// Input channel: in_valid / in_stall with number_value; an item is taken at
// a rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with word_token and last_token; one
// token per accepted output cycle, last_token marks the final token of a
// number. A number yields from 1 to 19 tokens.
// The front splitter extracts one decimal digit per cycle and takes the next
// item in the cycle it hands the digits to a two-entry queue; it never holds
// more than one number at a time.
// The back sequencer emits one token per cycle while out_stall is low, with
// no gap between numbers when the next digit set is already in the queue.
// The first token of a number appears once its digits have passed the
// splitter, the queue and the sequencer's slot mask register.
// When the receiver stalls, the token on the output holds; the queue fills
// and the front keeps in_stall high until it can push its finished digits.
// Synchronous reset empties the splitter, the queue and the sequencer.
module number_to_word_tokens
  import num2w_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] number_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  word_token,
  output logic        last_token
);

  logic    push;
  digits_t push_data;
  logic    q_full;
  logic    pop;
  digits_t pop_data;
  logic    q_empty;

  // Digit splitter.
  num2w_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number_value (number_value),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  // Queue of digit sets.
  num2w_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Token sequencer.
  num2w_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_token (word_token),
    .last_token (last_token)
  );

endmodule

// ===== test/tb_number_to_word_tokens.sv =====
module tb_number_to_word_tokens;
  import num2w_pkg::*;

  localparam int unsigned OneBillion  = 1000000000;
  localparam int unsigned OneMillion  = 1000000;
  localparam int unsigned OneThousand = 1000;

  // One spoken word as it should appear on the output channel.
  typedef struct packed {
    token_t token;
    logic   last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] number_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  word_token;
  logic        last_token;

  // Numbers waiting to be offered, and the words still owed by the block.
  logic [31:0] pending_numbers[$];
  word_t       expected_words[$];
  token_t      spoken[$];

  int  queued_count = 0;
  int  accepted_count = 0;
  int  errors = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  bit  quiet = 1'b0;
  bit  number_held;

  number_to_word_tokens dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number_value (number_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .word_token   (word_token),
    .last_token   (last_token)
  );

  always #5 clk = ~clk;

  // Append one word to the sequence being built.
  function automatic void add_word(input token_t t);
    spoken.insert(spoken.size(), t);
  endfunction

  // Speak one group below one thousand; "and" goes before the tens and ones after a hundred or when joined.
  function automatic void say_group(input int unsigned grp, input bit joined);
    int unsigned hund;
    int unsigned rest;
    hund = grp / 100;
    rest = grp % 100;
    if (grp == 0) return;
    if (hund > 0) begin
      add_word(token_t'(hund));
      add_word(TokHundred);
      joined = 1'b1;
    end
    if (joined && rest > 0) add_word(TokAnd);
    if (rest >= 20) begin
      add_word(TokTensBase + token_t'(rest / 10));
      if (rest % 10 > 0) add_word(token_t'(rest % 10));
    end else if (rest > 0) begin
      add_word(token_t'(rest));
    end
  endfunction

  // Work out the full word sequence of a number and queue it as expected.
  function automatic void speak_number(input logic [31:0] value);
    int unsigned n;
    word_t w;
    n = value;
    spoken.delete();
    if (n == 0) begin
      add_word(TokZero);
    end else begin
      if (n >= OneBillion) begin
        say_group(n / OneBillion, 1'b0);
        add_word(TokBillion);
        n = n % OneBillion;
      end
      if (n >= OneMillion) begin
        say_group(n / OneMillion, 1'b0);
        add_word(TokMillion);
        n = n % OneMillion;
      end
      if (n >= OneThousand) begin
        say_group(n / OneThousand, 1'b0);
        add_word(TokThousand);
        n = n % OneThousand;
      end
      if (n > 0) say_group(n, spoken.size() > 0);
    end
    foreach (spoken[k]) begin
      w.token = spoken[k];
      w.last  = (k == spoken.size() - 1);
      expected_words.insert(expected_words.size(), w);
    end
  endfunction

  // A random group value, weighted toward zero and the tricky shapes.
  function automatic int unsigned pick_group();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1, 19);
      2: return $urandom_range(20, 99);
      3: return 100 * $urandom_range(1, 9);
      default: return $urandom_range(100, 999);
    endcase
  endfunction

  // A random number: fully random bits, a number below one thousand, or built group by group.
  function automatic logic [31:0] pick_number();
    longint unsigned v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2: v = $urandom_range(999);
      default: begin
        v = 64'(OneBillion) * $urandom_range(4) + 64'(OneMillion) * pick_group()
            + 64'(OneThousand) * pick_group() + pick_group();
        if (v > 64'hFFFF_FFFF) v = v - OneBillion;
      end
    endcase
    return v[31:0];
  endfunction

  // Sender: takes numbers from the pending queue and idles in bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      number_value <= '0;
      send_gap     <= 0;
    end else begin
      number_held = in_valid;
      if (in_valid && !in_stall) begin
        speak_number(number_value);
        accepted_count++;
        number_held = 1'b0;
      end
      if (!number_held) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(99) < in_idle_pct) begin
          send_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_numbers.size() > 0) begin
          number_value <= pending_numbers.pop_front();
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted word and stalls in bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, got token %0d last %0b",
                   $time, word_token, last_token);
        end else begin
          if (word_token !== expected_words[0].token) begin
            errors++;
            $display("%0t: word_token expected %0d, got %0d",
                     $time, expected_words[0].token, word_token);
          end
          if (last_token !== expected_words[0].last) begin
            errors++;
            $display("%0t: last_token expected %0b, got %0b",
                     $time, expected_words[0].last, last_token);
          end
          void'(expected_words.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(99) < out_idle_pct) begin
        stall_left <= $urandom_range(0, 12);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus sequence: directed numbers, random batches, then a quiet tail.
  initial begin
    logic [31:0] directed_numbers[$] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd13, 32'd19, 32'd20, 32'd21, 32'd45,
      32'd99, 32'd100, 32'd101, 32'd110, 32'd120, 32'd999, 32'd1000,
      32'd1001, 32'd1200, 32'd12000, 32'd100100, 32'd1000000,
      32'd1000000000, 32'd2000000005, 32'd3999999999, 32'hFFFF_FFFF
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 30;
    out_idle_pct = 30;
    foreach (directed_numbers[i]) begin
      pending_numbers.insert(pending_numbers.size(), directed_numbers[i]);
      queued_count++;
    end
    while (accepted_count < queued_count) @(posedge clk);
    // Hold off the sender until every word so far has come out.
    while (expected_words.size() != 0) @(posedge clk);

    for (int batch = 0; batch < 7; batch++) begin
      case ($urandom_range(2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 8;
        default: in_idle_pct = 30;
      endcase
      case ($urandom_range(2))
        0: out_idle_pct = 0;
        1: out_idle_pct = 8;
        default: out_idle_pct = 30;
      endcase
      for (int i = 0; i < 40; i++) begin
        pending_numbers.insert(pending_numbers.size(), pick_number());
        queued_count++;
      end
      while (accepted_count < queued_count) @(posedge clk);
      if (batch == 3) begin
        while (expected_words.size() != 0) @(posedge clk);
      end
    end

    // Final stretch at full rate on both sides.
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) begin
      pending_numbers.insert(pending_numbers.size(), pick_number());
      queued_count++;
    end
    while (accepted_count < queued_count) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
